### src/mld_pkg.sv
// Shared constants, types and the arctangent table for the mouse-look direction block.
`default_nettype none
package mld_pkg;

  localparam int ANGLE_BITS    = 32;
  localparam int CORDIC_STAGES = 16;
  localparam int OUT_BITS      = 16;

  localparam int MAX_STAGES  = 24;
  localparam int CORDIC_FRAC = 30;
  localparam int CX_W        = CORDIC_FRAC + 2;
  localparam int Z_W         = ANGLE_BITS + 1;
  localparam int CUR_W       = 16;
  localparam int APP_W       = 24;
  localparam int PLIM_W      = 30;
  localparam int CFG_W       = 30;
  localparam int CFG_IDX_W   = 1;
  localparam int SH_W        = $clog2(MAX_STAGES);

  localparam logic signed [CX_W-1:0] CORDIC_GAIN = CX_W'(652032874);
  localparam logic [APP_W-1:0]       APP_RESET   = APP_W'(1193046);
  localparam logic [PLIM_W-1:0]      PLIM_RESET  = PLIM_W'(1061811541);

  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_PER_PIXEL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_LIMIT     = 1'b1;

  localparam logic [31:0] ATAN_TURN32 [MAX_STAGES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef struct packed {
    logic signed [CX_W-1:0] yaw_x;
    logic signed [CX_W-1:0] yaw_y;
    logic signed [Z_W-1:0]  yaw_z;
    logic signed [CX_W-1:0] pit_x;
    logic signed [CX_W-1:0] pit_y;
    logic signed [Z_W-1:0]  pit_z;
    logic                   neg;
  } cord_t;

  function automatic logic [ANGLE_BITS-1:0] atan_angle(input logic [SH_W-1:0] idx);
    logic [31:0] t;
    t = ATAN_TURN32[idx] >> (32 - ANGLE_BITS);
    return t[ANGLE_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

### src/mld_track.sv
// Cursor delta, yaw wrap and pitch clamp stages, and the yaw quadrant fold.
`default_nettype none
module mld_track (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic signed [mld_pkg::CUR_W-1:0] in_cursor_x,
  input  wire logic signed [mld_pkg::CUR_W-1:0] in_cursor_y,
  input  wire logic [mld_pkg::APP_W-1:0]        angle_per_pixel,
  input  wire logic [mld_pkg::PLIM_W-1:0]       pitch_limit,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output mld_pkg::cord_t                        out_data
);
  import mld_pkg::*;

  localparam int DX_W   = CUR_W + 1;
  localparam int PROD_W = DX_W + APP_W + 1;
  localparam int SUM_W  = PROD_W + 1;
  localparam logic signed [SUM_W-1:0] QUARTER = SUM_W'(64'd1 << (ANGLE_BITS - 2));
  localparam logic signed [Z_W-1:0]   QZ      = Z_W'(64'd1 << (ANGLE_BITS - 2));
  localparam logic signed [Z_W-1:0]   HZ      = Z_W'(64'd1 << (ANGLE_BITS - 1));

  logic                    first_r;
  logic signed [CUR_W-1:0] prev_x_r, prev_y_r;
  logic                    a_valid_r, b_valid_r, c_valid_r;
  logic signed [PROD_W-1:0] a_prod_x_r, a_prod_y_r;
  logic [ANGLE_BITS-1:0]        yaw_r, yaw_nxt;
  logic signed [ANGLE_BITS-1:0] pitch_r, pitch_nxt;
  cord_t                   c_data_r, c_data_nxt;

  logic a_adv, b_adv, c_adv;
  logic signed [CUR_W-1:0]  base_x, base_y;
  logic signed [DX_W-1:0]   dx, dy;
  logic signed [APP_W:0]    app_s;
  logic signed [PROD_W-1:0] prod_x, prod_y;
  logic signed [SUM_W-1:0]  sum, plim_e, lim_s, pitch_sum;
  logic signed [Z_W-1:0]    ya_e;

  assign c_adv    = ~c_valid_r | out_ready;
  assign b_adv    = ~b_valid_r | c_adv;
  assign a_adv    = ~a_valid_r | b_adv;
  assign in_ready = a_adv;

  assign base_x = first_r ? in_cursor_x : prev_x_r;
  assign base_y = first_r ? in_cursor_y : prev_y_r;
  assign dx     = DX_W'(in_cursor_x) - DX_W'(base_x);
  assign dy     = DX_W'(base_y) - DX_W'(in_cursor_y);
  assign app_s  = signed'({1'b0, angle_per_pixel});
  assign prod_x = dx * app_s;
  assign prod_y = dy * app_s;

  always_comb begin
    yaw_nxt = yaw_r + a_prod_x_r[ANGLE_BITS-1:0];
    sum     = SUM_W'(pitch_r) + SUM_W'(a_prod_y_r);
    plim_e  = SUM_W'(signed'({1'b0, pitch_limit}));
    lim_s   = (plim_e > QUARTER) ? QUARTER : plim_e;
    priority if (sum > lim_s) begin
      pitch_sum = lim_s;
    end else if (sum < -lim_s) begin
      pitch_sum = -lim_s;
    end else begin
      pitch_sum = sum;
    end
    pitch_nxt = pitch_sum[ANGLE_BITS-1:0];
  end

  always_comb begin
    ya_e             = Z_W'(signed'(yaw_r));
    c_data_nxt.yaw_x = CORDIC_GAIN;
    c_data_nxt.yaw_y = '0;
    c_data_nxt.pit_x = CORDIC_GAIN;
    c_data_nxt.pit_y = '0;
    c_data_nxt.pit_z = Z_W'(pitch_r);
    priority if (ya_e > QZ) begin
      c_data_nxt.yaw_z = ya_e - HZ;
      c_data_nxt.neg   = 1'b1;
    end else if (ya_e < -QZ) begin
      c_data_nxt.yaw_z = ya_e + HZ;
      c_data_nxt.neg   = 1'b1;
    end else begin
      c_data_nxt.yaw_z = ya_e;
      c_data_nxt.neg   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r   <= 1'b1;
      prev_x_r  <= '0;
      prev_y_r  <= '0;
      yaw_r     <= '0;
      pitch_r   <= '0;
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      if (a_adv) begin
        a_valid_r <= in_valid;
      end
      if (in_valid && a_adv) begin
        first_r  <= 1'b0;
        prev_x_r <= in_cursor_x;
        prev_y_r <= in_cursor_y;
      end
      if (b_adv) begin
        b_valid_r <= a_valid_r;
      end
      if (a_valid_r && b_adv) begin
        yaw_r   <= yaw_nxt;
        pitch_r <= pitch_nxt;
      end
      if (c_adv) begin
        c_valid_r <= b_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && a_adv) begin
      a_prod_x_r <= prod_x;
      a_prod_y_r <= prod_y;
    end
    if (b_valid_r && c_adv) begin
      c_data_r <= c_data_nxt;
    end
  end

  assign out_valid = c_valid_r;
  assign out_data  = c_data_r;

endmodule
`default_nettype wire

### src/mld_cordic_cell.sv
// One CORDIC rotation step for the yaw and pitch rotators, with its own pipeline register.
`default_nettype none
module mld_cordic_cell (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire mld_pkg::cord_t                 in_data,
  input  wire logic [mld_pkg::SH_W-1:0]       shamt,
  input  wire logic [mld_pkg::ANGLE_BITS-1:0] atan,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output mld_pkg::cord_t                      out_data
);
  import mld_pkg::*;

  logic                  valid_r;
  cord_t                 data_r, data_nxt;
  logic                  adv;
  logic signed [Z_W-1:0] t;

  assign t        = signed'({1'b0, atan});
  assign adv      = ~valid_r | out_ready;
  assign in_ready = adv;

  always_comb begin
    data_nxt = in_data;
    if (!in_data.yaw_z[Z_W-1]) begin
      data_nxt.yaw_x = in_data.yaw_x - (in_data.yaw_y >>> shamt);
      data_nxt.yaw_y = in_data.yaw_y + (in_data.yaw_x >>> shamt);
      data_nxt.yaw_z = in_data.yaw_z - t;
    end else begin
      data_nxt.yaw_x = in_data.yaw_x + (in_data.yaw_y >>> shamt);
      data_nxt.yaw_y = in_data.yaw_y - (in_data.yaw_x >>> shamt);
      data_nxt.yaw_z = in_data.yaw_z + t;
    end
    if (!in_data.pit_z[Z_W-1]) begin
      data_nxt.pit_x = in_data.pit_x - (in_data.pit_y >>> shamt);
      data_nxt.pit_y = in_data.pit_y + (in_data.pit_x >>> shamt);
      data_nxt.pit_z = in_data.pit_z - t;
    end else begin
      data_nxt.pit_x = in_data.pit_x + (in_data.pit_y >>> shamt);
      data_nxt.pit_y = in_data.pit_y - (in_data.pit_x >>> shamt);
      data_nxt.pit_z = in_data.pit_z + t;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && adv) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule
`default_nettype wire

### src/mld_output.sv
// Quadrant sign fix, yaw by pitch products, rounding and saturation to the output words.
`default_nettype none
module mld_output (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire mld_pkg::cord_t                      in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [mld_pkg::OUT_BITS-1:0]      out_dir_x,
  output logic signed [mld_pkg::OUT_BITS-1:0]      out_dir_y,
  output logic signed [mld_pkg::OUT_BITS-1:0]      out_dir_z
);
  import mld_pkg::*;

  localparam int PW  = 2 * CX_W;
  localparam int PSH = 2 * CORDIC_FRAC - (OUT_BITS - 1);
  localparam int SSH = CORDIC_FRAC - (OUT_BITS - 1);
  localparam logic signed [PW:0] PRND = (PW+1)'(65'd1 << (PSH - 1));
  localparam logic signed [PW:0] SRND = (PW+1)'(65'd1 << (SSH - 1));
  localparam logic signed [PW:0] HI   = (PW+1)'((65'd1 << (OUT_BITS - 1)) - 65'd1);
  localparam logic signed [PW:0] LO   = -HI - (PW+1)'(1);

  function automatic logic [OUT_BITS-1:0] sat_out(input logic signed [PW:0] v);
    logic signed [PW:0] r;
    r = (v > HI) ? HI : ((v < LO) ? LO : v);
    return r[OUT_BITS-1:0];
  endfunction

  logic                   p1_valid_r, out_valid_r;
  logic signed [PW-1:0]   prod_x_r, prod_z_r;
  logic signed [CX_W-1:0] sp_r;
  logic signed [OUT_BITS-1:0] dir_x_r, dir_y_r, dir_z_r;

  logic p1_adv, p2_adv;
  logic signed [CX_W-1:0] cy, sy;
  logic signed [PW-1:0]   prod_x, prod_z;
  logic signed [PW:0]     rnd_x, rnd_y, rnd_z;

  assign p2_adv   = ~out_valid_r | out_ready;
  assign p1_adv   = ~p1_valid_r | p2_adv;
  assign in_ready = p1_adv;

  assign cy     = in_data.neg ? -in_data.yaw_x : in_data.yaw_x;
  assign sy     = in_data.neg ? -in_data.yaw_y : in_data.yaw_y;
  assign prod_x = cy * in_data.pit_x;
  assign prod_z = sy * in_data.pit_x;

  assign rnd_x = ((PW+1)'(prod_x_r) + PRND) >>> PSH;
  assign rnd_z = ((PW+1)'(prod_z_r) + PRND) >>> PSH;
  assign rnd_y = ((PW+1)'(sp_r) + SRND) >>> SSH;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (p1_adv) begin
        p1_valid_r <= in_valid;
      end
      if (p2_adv) begin
        out_valid_r <= p1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && p1_adv) begin
      prod_x_r <= prod_x;
      prod_z_r <= prod_z;
      sp_r     <= in_data.pit_y;
    end
    if (p1_valid_r && p2_adv) begin
      dir_x_r <= sat_out(rnd_x);
      dir_y_r <= sat_out(rnd_y);
      dir_z_r <= sat_out(rnd_z);
    end
  end

  assign out_valid = out_valid_r;
  assign out_dir_x = dir_x_r;
  assign out_dir_y = dir_y_r;
  assign out_dir_z = dir_z_r;

endmodule
`default_nettype wire

### src/mouse_look_direction.sv
// Top level: configuration registers, tracking front end, CORDIC cell chain and output stage.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+--------------------------------
//  in       | input     | in_valid / in_ready  | in_cursor_x, in_cursor_y
//  out      | output    | out_valid / out_ready| out_dir_x, out_dir_y, out_dir_z
//  cfg      | input     | cfg_we               | cfg_index, cfg_data
//
// One transaction per cycle sustained while out_ready is high. The pipeline holds three
// tracking stages, one register per CORDIC cell (CORDIC_STAGES cells) and two output stages.
// Every stage has its own valid bit, so a stall at out_ready fills empty stages
// before in_ready drops. Synchronous reset empties the pipeline, restores the
// register defaults and marks the next cursor sample as the seed.
`default_nettype none
module mouse_look_direction (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [mld_pkg::CUR_W-1:0]    in_cursor_x,
  input  wire logic signed [mld_pkg::CUR_W-1:0]    in_cursor_y,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [mld_pkg::OUT_BITS-1:0]      out_dir_x,
  output logic signed [mld_pkg::OUT_BITS-1:0]      out_dir_y,
  output logic signed [mld_pkg::OUT_BITS-1:0]      out_dir_z,
  input  wire logic                                cfg_we,
  input  wire logic [mld_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [mld_pkg::CFG_W-1:0]           cfg_data
);
  import mld_pkg::*;

  logic [APP_W-1:0]  app_r;
  logic [PLIM_W-1:0] plim_r;

  logic  chain_valid [CORDIC_STAGES+1];
  logic  chain_ready [CORDIC_STAGES+1];
  cord_t chain_data  [CORDIC_STAGES+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      app_r  <= APP_RESET;
      plim_r <= PLIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ANGLE_PER_PIXEL: app_r  <= cfg_data[APP_W-1:0];
        CFG_PITCH_LIMIT:     plim_r <= cfg_data[PLIM_W-1:0];
      endcase
    end
  end

  mld_track u_track (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cursor_x     (in_cursor_x),
    .in_cursor_y     (in_cursor_y),
    .angle_per_pixel (app_r),
    .pitch_limit     (plim_r),
    .out_valid       (chain_valid[0]),
    .out_ready       (chain_ready[0]),
    .out_data        (chain_data[0])
  );

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    mld_cordic_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (chain_valid[i]),
      .in_ready  (chain_ready[i]),
      .in_data   (chain_data[i]),
      .shamt     (SH_W'(i)),
      .atan      (atan_angle(SH_W'(i))),
      .out_valid (chain_valid[i+1]),
      .out_ready (chain_ready[i+1]),
      .out_data  (chain_data[i+1])
    );
  end

  mld_output u_output (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (chain_valid[CORDIC_STAGES]),
    .in_ready  (chain_ready[CORDIC_STAGES]),
    .in_data   (chain_data[CORDIC_STAGES]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_dir_x (out_dir_x),
    .out_dir_y (out_dir_y),
    .out_dir_z (out_dir_z)
  );

endmodule
`default_nettype wire

### src/mld_checker.sv
// Port-level assertions for the mouse-look direction block and their bind.
`default_nettype none
module mld_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_ready,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic signed [mld_pkg::OUT_BITS-1:0] out_dir_x,
  input wire logic signed [mld_pkg::OUT_BITS-1:0] out_dir_y,
  input wire logic signed [mld_pkg::OUT_BITS-1:0] out_dir_z
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_dir_x) && $stable(out_dir_y)
      && $stable(out_dir_z))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_reset_ready: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready right after reset");

  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with nothing waiting at the output");

endmodule

bind mouse_look_direction mld_checker u_mld_checker (.*);
`default_nettype wire
